@@ src/ovr_pkg.sv @@
// Shared types and constants of the one-vs-rest logistic trainer.
// Holds opcodes, status codes, register indexes, the controller-to-datapath
// command and status structs, and the sigmoid lookup table.
`default_nettype none

package ovr_pkg;

  // Input opcodes
  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_TRAIN   = 2'd1;
  localparam logic [1:0] OP_PREDICT = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_STORE_FULL = 2'd1;
  localparam logic [1:0] ST_NO_SAMPLES = 2'd2;
  localparam logic [1:0] ST_TABLE_FULL = 2'd3;

  // Configuration register indexes and reset values
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 20;
  localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ITERATION_COUNT = 2'd1;
  localparam logic [15:0] LEARNING_RATE_RESET   = 16'd66;
  localparam logic [19:0] ITERATION_COUNT_RESET = 20'd100000;

  // Bias input 1.0 in Q8.8 and the saturated sigmoid value
  localparam logic signed [15:0] BIAS_ONE = 16'sd256;
  localparam logic [15:0] SIG_TOP = 16'd65514;

  // Controller commands to the datapath
  typedef struct packed {
    logic       accept;     // latch the input item, clear the best result
    logic       smp_we;     // store the latched sample
    logic       smp_re;     // read one stored sample
    logic       mdl_re;     // read one stored model
    logic       mdl_we;     // store working weights as a model
    logic       clr_w;      // zero working weights
    logic       clr_g;      // zero gradient sums
    logic       use_model;  // dot product on model weights and input features
    logic       mac;        // one dot product term
    logic       sig1;       // sigmoid: magnitude and table lookup
    logic       sig2;       // sigmoid: interpolation and error
    logic       grad;       // one gradient term
    logic       div_start;  // load divider with |g[wsel]|
    logic       div_step;   // one quotient bit
    logic       mul_start;  // load rate multiplier with the quotient
    logic       mul_step;   // one rate bit
    logic       apply;      // saturating update of w[wsel]
    logic       best_upd;   // compare model output against best so far
    logic [1:0] wsel;       // weight index
  } ovr_cmd_t;

  // Datapath status to the controller
  typedef struct packed {
    logic div_last;
    logic mul_last;
  } ovr_stat_t;

  // Sigmoid at k/2 for k = 0..16, Q0.16
  function automatic logic [15:0] sig_tab(input logic [4:0] k);
    logic [15:0] v;
    case (k)
      5'd0:    v = 16'd32768;
      5'd1:    v = 16'd40793;
      5'd2:    v = 16'd47911;
      5'd3:    v = 16'd53581;
      5'd4:    v = 16'd57724;
      5'd5:    v = 16'd60565;
      5'd6:    v = 16'd62428;
      5'd7:    v = 16'd63615;
      5'd8:    v = 16'd64357;
      5'd9:    v = 16'd64816;
      5'd10:   v = 16'd65097;
      5'd11:   v = 16'd65269;
      5'd12:   v = 16'd65374;
      5'd13:   v = 16'd65437;
      5'd14:   v = 16'd65476;
      5'd15:   v = 16'd65500;
      default: v = 16'd65514;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

@@ src/ovr_dpath.sv @@
// Datapath of the one-vs-rest logistic trainer: sample and model memories,
// dot product, sigmoid, gradient sums, serial divider and rate multiplier.
// Depends on ovr_pkg for the command and status structs and the sigmoid table.
`default_nettype none

module ovr_dpath #(
  parameter int unsigned MAX_SAMPLES = 256,
  parameter int unsigned MAX_MODELS  = 8,
  localparam int unsigned SA_W    = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1,
  localparam int unsigned MA_W    = (MAX_MODELS > 1) ? $clog2(MAX_MODELS) : 1,
  localparam int unsigned CNT_W   = $clog2(MAX_SAMPLES + 1)
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  ovr_pkg::ovr_cmd_t        cmd_i,
  output ovr_pkg::ovr_stat_t       stat_o,
  input  wire logic signed [15:0]  feature_a_i,
  input  wire logic signed [15:0]  feature_b_i,
  input  wire logic [7:0]          class_label_i,
  input  wire logic [15:0]         learning_rate_i,
  input  wire logic [SA_W-1:0]     smp_addr_i,
  input  wire logic [MA_W-1:0]     mdl_rd_addr_i,
  input  wire logic [MA_W-1:0]     mdl_wr_addr_i,
  input  wire logic [CNT_W-1:0]    scnt_i,
  output logic [7:0]               best_class_o,
  output logic [15:0]              best_prob_o
);

  localparam int unsigned G_W    = 33 + $clog2(MAX_SAMPLES);
  localparam int unsigned MAG_W  = G_W;
  localparam int unsigned PROD_W = MAG_W + 16;
  localparam int unsigned P_W    = PROD_W - 24;
  localparam int unsigned SUM_W  = ((P_W > 32) ? P_W : 32) + 2;
  localparam int unsigned UC_W   = $clog2(MAG_W + 1);
  localparam int unsigned REM_W  = CNT_W + 1;
  localparam int unsigned ACC_W  = 50;

  // Latched input item
  logic signed [15:0] fa_q, fb_q;
  logic [7:0]         cls_q;

  // Memories
  logic [39:0]  smp_mem [MAX_SAMPLES];
  logic [39:0]  smp_rd_q;
  logic [103:0] mdl_mem [MAX_MODELS];
  logic [103:0] mdl_rd_q;

  // Arithmetic state
  logic signed [31:0]    w_q [3];
  logic signed [G_W-1:0] g_q [3];
  logic signed [ACC_W-1:0] acc_q;
  logic                  neg_q, sat_q;
  logic [15:0]           base_q;
  logic [13:0]           d_q;
  logic [22:0]           frac_q;
  logic [15:0]           sig_q;
  logic signed [17:0]    err_q;
  logic [MAG_W-1:0]      q_q;
  logic [REM_W-1:0]      rem_q;
  logic                  gneg_q;
  logic [PROD_W-1:0]     prod_q, mc_q;
  logic [15:0]           lrs_q;
  logic [UC_W-1:0]       ucnt_q;
  logic [7:0]            best_cls_q;
  logic [15:0]           best_p_q;

  // Operand selection
  logic signed [15:0] src_a, src_b, x_cur;
  logic signed [31:0] w_work, w_model, w_cur;
  logic signed [G_W-1:0] g_cur;

  assign src_a = cmd_i.use_model ? fa_q : $signed(smp_rd_q[15:0]);
  assign src_b = cmd_i.use_model ? fb_q : $signed(smp_rd_q[31:16]);

  always_comb begin
    case (cmd_i.wsel)
      2'd0: begin
        x_cur   = ovr_pkg::BIAS_ONE;
        w_work  = w_q[0];
        w_model = $signed(mdl_rd_q[31:0]);
        g_cur   = g_q[0];
      end
      2'd1: begin
        x_cur   = src_a;
        w_work  = w_q[1];
        w_model = $signed(mdl_rd_q[63:32]);
        g_cur   = g_q[1];
      end
      default: begin
        x_cur   = src_b;
        w_work  = w_q[2];
        w_model = $signed(mdl_rd_q[95:64]);
        g_cur   = g_q[2];
      end
    endcase
  end

  assign w_cur = cmd_i.use_model ? w_model : w_work;

  // Dot product term
  logic signed [47:0] dot_prod;
  assign dot_prod = w_cur * x_cur;

  // Sigmoid stage one: magnitude, segment and table lookup
  logic [ACC_W-1:0] abs_z;
  logic [3:0]       seg;
  logic [15:0]      tab_lo, tab_hi;
  assign abs_z  = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
  assign seg    = abs_z[26:23];
  assign tab_lo = ovr_pkg::sig_tab({1'b0, seg});
  assign tab_hi = ovr_pkg::sig_tab({1'b0, seg} + 5'd1);

  // Sigmoid stage two: interpolate, mirror, subtract target
  logic [36:0]        interp;
  logic [15:0]        v_pos, sig_v;
  logic               match;
  logic signed [17:0] err_v;
  assign interp = d_q * frac_q;
  assign v_pos  = sat_q ? ovr_pkg::SIG_TOP : base_q + {2'b00, interp[36:23]};
  assign sig_v  = neg_q ? 16'(17'h10000 - {1'b0, v_pos}) : v_pos;
  assign match  = (smp_rd_q[39:32] == cls_q);
  assign err_v  = $signed({2'b00, sig_v}) - (match ? 18'sh10000 : 18'sh0);

  // Gradient term
  logic signed [33:0] grad_prod;
  assign grad_prod = err_q * x_cur;

  // Divider step
  logic [MAG_W-1:0] g_mag;
  logic [REM_W-1:0] rsh, n_ext;
  logic             ge;
  assign g_mag = g_cur[G_W-1] ? MAG_W'(-g_cur) : MAG_W'(g_cur);
  assign rsh   = {rem_q[REM_W-2:0], q_q[MAG_W-1]};
  assign n_ext = {1'b0, scnt_i};
  assign ge    = (rsh >= n_ext);

  // Weight update with saturation
  logic [P_W-1:0]          p_step;
  logic signed [SUM_W-1:0] w_ext, p_ext, nw;
  logic signed [31:0]      w_sat;
  assign p_step = prod_q[PROD_W-1:24];
  assign w_ext  = SUM_W'(w_work);
  assign p_ext  = $signed({{(SUM_W - P_W){1'b0}}, p_step});
  assign nw     = gneg_q ? w_ext + p_ext : w_ext - p_ext;

  always_comb begin
    if (&nw[SUM_W-1:31] || ~|nw[SUM_W-1:31]) begin
      w_sat = nw[31:0];
    end else if (nw[SUM_W-1]) begin
      w_sat = 32'sh8000_0000;
    end else begin
      w_sat = 32'sh7fff_ffff;
    end
  end

  // Memories: one write and one registered read each
  always_ff @(posedge clk_i) begin
    if (cmd_i.smp_we) begin
      smp_mem[smp_addr_i] <= {cls_q, fb_q, fa_q};
    end
    if (cmd_i.smp_re) begin
      smp_rd_q <= smp_mem[smp_addr_i];
    end
    if (cmd_i.mdl_we) begin
      mdl_mem[mdl_wr_addr_i] <= {cls_q, w_q[2], w_q[1], w_q[0]};
    end
    if (cmd_i.mdl_re) begin
      mdl_rd_q <= mdl_mem[mdl_rd_addr_i];
    end
  end

  // Input latch, dot product, sigmoid and best tracking
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      fa_q       <= feature_a_i;
      fb_q       <= feature_b_i;
      cls_q      <= class_label_i;
      best_cls_q <= 8'd0;
      best_p_q   <= 16'd0;
    end
    if (cmd_i.mac) begin
      acc_q <= (cmd_i.wsel == 2'd0) ? ACC_W'(dot_prod) : acc_q + ACC_W'(dot_prod);
    end
    if (cmd_i.sig1) begin
      neg_q  <= acc_q[ACC_W-1];
      sat_q  <= |abs_z[ACC_W-1:27];
      base_q <= tab_lo;
      d_q    <= 14'(tab_hi - tab_lo);
      frac_q <= abs_z[22:0];
    end
    if (cmd_i.sig2) begin
      sig_q <= sig_v;
      err_q <= err_v;
    end
    if (cmd_i.best_upd && (sig_q > best_p_q)) begin
      best_p_q   <= sig_q;
      best_cls_q <= mdl_rd_q[103:96];
    end
  end

  // Weights and gradient sums
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      if (cmd_i.clr_w) begin
        w_q[k] <= 32'sd0;
      end else if (cmd_i.apply && (cmd_i.wsel == 2'(k))) begin
        w_q[k] <= w_sat;
      end
      if (cmd_i.clr_g) begin
        g_q[k] <= '0;
      end else if (cmd_i.grad && (cmd_i.wsel == 2'(k))) begin
        g_q[k] <= g_q[k] + G_W'($signed(grad_prod[31:0]));
      end
    end
  end

  // Serial divider and rate multiplier
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      q_q    <= g_mag;
      rem_q  <= '0;
      gneg_q <= g_cur[G_W-1];
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? rsh - n_ext : rsh;
      q_q   <= {q_q[MAG_W-2:0], ge};
    end
    if (cmd_i.mul_start) begin
      prod_q <= '0;
      mc_q   <= PROD_W'(q_q);
      lrs_q  <= learning_rate_i;
    end else if (cmd_i.mul_step) begin
      if (lrs_q[0]) begin
        prod_q <= prod_q + mc_q;
      end
      mc_q  <= {mc_q[PROD_W-2:0], 1'b0};
      lrs_q <= {1'b0, lrs_q[15:1]};
    end
  end

  // Step counter for the serial units
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ucnt_q <= '0;
    end else if (cmd_i.div_start) begin
      ucnt_q <= UC_W'(MAG_W);
    end else if (cmd_i.mul_start) begin
      ucnt_q <= UC_W'(16);
    end else if (cmd_i.div_step || cmd_i.mul_step) begin
      ucnt_q <= ucnt_q - UC_W'(1);
    end
  end

  assign stat_o = '{div_last: (ucnt_q == UC_W'(1)), mul_last: (ucnt_q == UC_W'(1))};
  assign best_class_o    = best_cls_q;
  assign best_prob_o     = best_p_q;

endmodule

`default_nettype wire

@@ src/ovr_ctrl.sv @@
// Controller of the one-vs-rest logistic trainer: item decode, sample and
// model counts, loop counters and the sequencer that drives ovr_dpath.
// Depends on ovr_pkg for opcodes, status codes and the command struct.
`default_nettype none

module ovr_ctrl #(
  parameter int unsigned MAX_SAMPLES   = 256,
  parameter int unsigned FEATURE_COUNT = 2,
  parameter int unsigned MAX_MODELS    = 8,
  localparam int unsigned SA_W  = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1,
  localparam int unsigned MA_W  = (MAX_MODELS > 1) ? $clog2(MAX_MODELS) : 1,
  localparam int unsigned CNT_W = $clog2(MAX_SAMPLES + 1)
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  input  wire logic [1:0]       opcode_i,
  output logic                  in_stall_o,
  input  wire logic [19:0]      iteration_count_i,
  input  ovr_pkg::ovr_stat_t    stat_i,
  output ovr_pkg::ovr_cmd_t     cmd_o,
  output logic [SA_W-1:0]       smp_addr_o,
  output logic [MA_W-1:0]       mdl_rd_addr_o,
  output logic [MA_W-1:0]       mdl_wr_addr_o,
  output logic [CNT_W-1:0]      scnt_o,
  input  wire                   out_free_i,
  output logic                  push_o,
  output logic [1:0]            status_o
);

  localparam int unsigned MC_W  = $clog2(MAX_MODELS + 1);
  localparam int unsigned IDX_W = (SA_W > MA_W) ? SA_W : MA_W;
  localparam int unsigned CMP_W = IDX_W + 1;
  localparam logic [1:0]  LAST_W = 2'(FEATURE_COUNT);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_LOAD   = 5'd1;
  localparam logic [4:0] S_T_INIT = 5'd2;
  localparam logic [4:0] S_T_RD   = 5'd3;
  localparam logic [4:0] S_T_DOT  = 5'd4;
  localparam logic [4:0] S_T_SIG1 = 5'd5;
  localparam logic [4:0] S_T_SIG2 = 5'd6;
  localparam logic [4:0] S_T_GRAD = 5'd7;
  localparam logic [4:0] S_U_DIV0 = 5'd8;
  localparam logic [4:0] S_U_DIV  = 5'd9;
  localparam logic [4:0] S_U_MUL0 = 5'd10;
  localparam logic [4:0] S_U_MUL  = 5'd11;
  localparam logic [4:0] S_U_APPLY = 5'd12;
  localparam logic [4:0] S_T_SAVE = 5'd13;
  localparam logic [4:0] S_P_RD   = 5'd14;
  localparam logic [4:0] S_P_DOT  = 5'd15;
  localparam logic [4:0] S_P_SIG1 = 5'd16;
  localparam logic [4:0] S_P_SIG2 = 5'd17;
  localparam logic [4:0] S_P_CMP  = 5'd18;
  localparam logic [4:0] S_PUSH   = 5'd19;

  logic [4:0]       state_q, state_d;
  logic [CNT_W-1:0] scnt_q, scnt_d;
  logic [MC_W-1:0]  mcnt_q, mcnt_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [1:0]       j_q, j_d;
  logic [19:0]      iter_q, iter_d;
  logic [1:0]       status_q, status_d;

  logic last_smp, last_mdl, last_j;
  assign last_smp = (CMP_W'(idx_q) + CMP_W'(1)) == CMP_W'(scnt_q);
  assign last_mdl = (CMP_W'(idx_q) + CMP_W'(1)) == CMP_W'(mcnt_q);
  assign last_j   = (j_q == LAST_W);

  assign in_stall_o    = (state_q != S_IDLE);
  assign smp_addr_o    = (state_q == S_LOAD) ? scnt_q[SA_W-1:0] : idx_q[SA_W-1:0];
  assign mdl_rd_addr_o = idx_q[MA_W-1:0];
  assign mdl_wr_addr_o = mcnt_q[MA_W-1:0];
  assign scnt_o        = scnt_q;
  assign status_o      = status_q;

  // Sequence one item
  always_comb begin
    state_d  = state_q;
    scnt_d   = scnt_q;
    mcnt_d   = mcnt_q;
    idx_d    = idx_q;
    j_d      = j_q;
    iter_d   = iter_q;
    status_d = status_q;
    cmd_o    = '0;
    cmd_o.wsel = j_q;
    push_o   = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          status_d     = ovr_pkg::ST_OK;
          idx_d        = '0;
          j_d          = 2'd0;
          unique case (opcode_i)
            ovr_pkg::OP_LOAD: state_d = S_LOAD;
            ovr_pkg::OP_TRAIN: begin
              if (scnt_q == '0) begin
                status_d = ovr_pkg::ST_NO_SAMPLES;
                state_d  = S_PUSH;
              end else if (mcnt_q == MC_W'(MAX_MODELS)) begin
                status_d = ovr_pkg::ST_TABLE_FULL;
                state_d  = S_PUSH;
              end else begin
                state_d = S_T_INIT;
              end
            end
            ovr_pkg::OP_PREDICT: state_d = (mcnt_q == '0) ? S_PUSH : S_P_RD;
            default: state_d = S_PUSH;
          endcase
        end
      end
      S_LOAD: begin
        if (scnt_q == CNT_W'(MAX_SAMPLES)) begin
          status_d = ovr_pkg::ST_STORE_FULL;
        end else begin
          cmd_o.smp_we = 1'b1;
          scnt_d       = scnt_q + CNT_W'(1);
        end
        state_d = S_PUSH;
      end
      S_T_INIT: begin
        cmd_o.clr_w = 1'b1;
        cmd_o.clr_g = 1'b1;
        iter_d      = '0;
        idx_d       = '0;
        state_d     = (iteration_count_i == '0) ? S_T_SAVE : S_T_RD;
      end
      S_T_RD: begin
        cmd_o.smp_re = 1'b1;
        j_d          = 2'd0;
        state_d      = S_T_DOT;
      end
      S_T_DOT: begin
        cmd_o.mac = 1'b1;
        if (last_j) begin
          state_d = S_T_SIG1;
        end else begin
          j_d = j_q + 2'd1;
        end
      end
      S_T_SIG1: begin
        cmd_o.sig1 = 1'b1;
        state_d    = S_T_SIG2;
      end
      S_T_SIG2: begin
        cmd_o.sig2 = 1'b1;
        j_d        = 2'd0;
        state_d    = S_T_GRAD;
      end
      S_T_GRAD: begin
        cmd_o.grad = 1'b1;
        if (last_j) begin
          j_d = 2'd0;
          if (last_smp) begin
            state_d = S_U_DIV0;
          end else begin
            idx_d   = idx_q + IDX_W'(1);
            state_d = S_T_RD;
          end
        end else begin
          j_d = j_q + 2'd1;
        end
      end
      S_U_DIV0: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_U_DIV;
      end
      S_U_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = S_U_MUL0;
        end
      end
      S_U_MUL0: begin
        cmd_o.mul_start = 1'b1;
        state_d         = S_U_MUL;
      end
      S_U_MUL: begin
        cmd_o.mul_step = 1'b1;
        if (stat_i.mul_last) begin
          state_d = S_U_APPLY;
        end
      end
      S_U_APPLY: begin
        cmd_o.apply = 1'b1;
        if (last_j) begin
          j_d = 2'd0;
          if (iter_q + 20'd1 == iteration_count_i) begin
            state_d = S_T_SAVE;
          end else begin
            iter_d      = iter_q + 20'd1;
            cmd_o.clr_g = 1'b1;
            idx_d       = '0;
            state_d     = S_T_RD;
          end
        end else begin
          j_d     = j_q + 2'd1;
          state_d = S_U_DIV0;
        end
      end
      S_T_SAVE: begin
        cmd_o.mdl_we = 1'b1;
        mcnt_d       = mcnt_q + MC_W'(1);
        state_d      = S_PUSH;
      end
      S_P_RD: begin
        cmd_o.mdl_re = 1'b1;
        j_d          = 2'd0;
        state_d      = S_P_DOT;
      end
      S_P_DOT: begin
        cmd_o.mac       = 1'b1;
        cmd_o.use_model = 1'b1;
        if (last_j) begin
          state_d = S_P_SIG1;
        end else begin
          j_d = j_q + 2'd1;
        end
      end
      S_P_SIG1: begin
        cmd_o.sig1 = 1'b1;
        state_d    = S_P_SIG2;
      end
      S_P_SIG2: begin
        cmd_o.sig2 = 1'b1;
        state_d    = S_P_CMP;
      end
      S_P_CMP: begin
        cmd_o.best_upd = 1'b1;
        if (last_mdl) begin
          state_d = S_PUSH;
        end else begin
          idx_d   = idx_q + IDX_W'(1);
          state_d = S_P_RD;
        end
      end
      S_PUSH: begin
        if (out_free_i) begin
          push_o  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      scnt_q   <= '0;
      mcnt_q   <= '0;
      idx_q    <= '0;
      j_q      <= 2'd0;
      iter_q   <= '0;
      status_q <= ovr_pkg::ST_OK;
    end else begin
      state_q  <= state_d;
      scnt_q   <= scnt_d;
      mcnt_q   <= mcnt_d;
      idx_q    <= idx_d;
      j_q      <= j_d;
      iter_q   <= iter_d;
      status_q <= status_d;
    end
  end

endmodule

`default_nettype wire

@@ src/one_vs_rest_logistic_trainer_unit.sv @@
// One-vs-rest logistic regression trainer and classifier. A load transaction
// stores one labelled sample. A train transaction fits one class with
// iteration_count batch gradient steps; each step walks all N stored samples
// through one shared multiply-accumulate and sigmoid path, then updates each
// of the FEATURE_COUNT+1 weights through a bit-serial divider and rate
// multiplier, so the serial units and the sample loop set the train time. A
// predict transaction makes one model memory read per model for M stored
// models. Each transaction returns one result; the next transaction is
// accepted while that result waits in the output register.
`default_nettype none

module one_vs_rest_logistic_trainer_unit #(
  parameter int unsigned MAX_SAMPLES   = 256,
  parameter int unsigned FEATURE_COUNT = 2,
  parameter int unsigned MAX_MODELS    = 8
) (
  input  wire                                     clk_i,
  input  wire                                     rst_ni,
  input  wire                                     in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic [1:0]                         opcode_i,
  input  wire logic signed [15:0]                 feature_a_i,
  input  wire logic signed [15:0]                 feature_b_i,
  input  wire logic [7:0]                         class_label_i,
  output logic                                    out_valid_o,
  input  wire                                     out_stall_i,
  output logic [1:0]                              status_o,
  output logic [7:0]                              predicted_class_o,
  output logic [15:0]                             probability_o,
  input  wire                                     cfg_we_i,
  input  wire logic [ovr_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [ovr_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned SA_W  = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int unsigned MA_W  = (MAX_MODELS > 1) ? $clog2(MAX_MODELS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_SAMPLES + 1);

  logic [15:0] lr_q;
  logic [19:0] iter_cnt_q;

  ovr_pkg::ovr_cmd_t  cmd;
  ovr_pkg::ovr_stat_t stat;
  logic [SA_W-1:0]  smp_addr;
  logic [MA_W-1:0]  mdl_rd_addr, mdl_wr_addr;
  logic [CNT_W-1:0] scnt;
  logic             push, out_free;
  logic [1:0]       ctrl_status;
  logic [7:0]       best_class;
  logic [15:0]      best_prob;

  logic        out_valid_q;
  logic [1:0]  out_status_q;
  logic [7:0]  out_class_q;
  logic [15:0] out_prob_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q       <= ovr_pkg::LEARNING_RATE_RESET;
      iter_cnt_q <= ovr_pkg::ITERATION_COUNT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        ovr_pkg::CFG_LEARNING_RATE:   lr_q       <= cfg_data_i[15:0];
        ovr_pkg::CFG_ITERATION_COUNT: iter_cnt_q <= cfg_data_i[19:0];
        default: ;
      endcase
    end
  end

  ovr_ctrl #(
    .MAX_SAMPLES   (MAX_SAMPLES),
    .FEATURE_COUNT (FEATURE_COUNT),
    .MAX_MODELS    (MAX_MODELS)
  ) u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .opcode_i          (opcode_i),
    .in_stall_o        (in_stall_o),
    .iteration_count_i (iter_cnt_q),
    .stat_i            (stat),
    .cmd_o             (cmd),
    .smp_addr_o        (smp_addr),
    .mdl_rd_addr_o     (mdl_rd_addr),
    .mdl_wr_addr_o     (mdl_wr_addr),
    .scnt_o            (scnt),
    .out_free_i        (out_free),
    .push_o            (push),
    .status_o          (ctrl_status)
  );

  ovr_dpath #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .MAX_MODELS  (MAX_MODELS)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .feature_a_i     (feature_a_i),
    .feature_b_i     (feature_b_i),
    .class_label_i   (class_label_i),
    .learning_rate_i (lr_q),
    .smp_addr_i      (smp_addr),
    .mdl_rd_addr_i   (mdl_rd_addr),
    .mdl_wr_addr_i   (mdl_wr_addr),
    .scnt_i          (scnt),
    .best_class_o    (best_class),
    .best_prob_o     (best_prob)
  );

  // Output register: load on push, drop when taken
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      out_status_q <= ctrl_status;
      out_class_q  <= best_class;
      out_prob_q   <= best_prob;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_status_q;
  assign predicted_class_o = out_class_q;
  assign probability_o     = out_prob_q;

  // Never overwrite a result that is still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (!out_valid_q || !out_stall_i))
    else $error("result pushed over a stalled result");

  // An accepted transaction blocks the input next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after accept");

  // Error results carry no class and no probability
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_status_q != ovr_pkg::ST_OK)) |->
      (out_class_q == 8'd0 && out_prob_q == 16'd0))
    else $error("error result with nonzero payload");

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
// Self-checking testbench for the one-vs-rest logistic trainer unit.
// Depends on ovr_pkg for opcodes, status codes and register indexes; a
// scoreboard class predicts each result and checks it against the block.
`default_nettype none

typedef struct {
  logic [1:0]  status;
  logic [7:0]  cls;
  logic [15:0] prob;
} ovr_result_t;

class ovr_scoreboard;
  localparam int SAMPLE_DEPTH = 256;
  localparam int MODEL_DEPTH  = 8;

  int unsigned curve [17] = '{32768, 40793, 47911, 53581, 57724, 60565, 62428, 63615,
                              64357, 64816, 65097, 65269, 65374, 65437, 65476, 65500,
                              65514};
  int unsigned      step_rate;
  int unsigned      step_count;
  logic signed [15:0] feat_a [SAMPLE_DEPTH];
  logic signed [15:0] feat_b [SAMPLE_DEPTH];
  logic [7:0]       labels [SAMPLE_DEPTH];
  int unsigned      sample_cnt;
  int               weights [MODEL_DEPTH][3];
  logic [7:0]       model_cls [MODEL_DEPTH];
  int unsigned      model_cnt;
  ovr_result_t      pending_q [$];
  int               errors;

  function new();
    step_rate  = 66;
    step_count = 100000;
    sample_cnt = 0;
    model_cnt  = 0;
    errors     = 0;
  endfunction

  function void set_reg(logic [ovr_pkg::CFG_IDX_W-1:0] idx, logic [19:0] val);
    if (idx == ovr_pkg::CFG_LEARNING_RATE) step_rate = val[15:0];
    else if (idx == ovr_pkg::CFG_ITERATION_COUNT) step_count = val;
  endfunction

  // Piecewise-linear logistic on a Q24.24 argument, Q0.16 result
  function int unsigned squash(longint z);
    longint unsigned mag;
    longint unsigned idx;
    int unsigned v;
    mag = (z < 0) ? longint'(0) - z : z;
    idx = mag >> 23;
    if (idx >= 16) v = curve[16];
    else v = curve[idx] + int'(((longint'(curve[idx+1] - curve[idx]))
                                * (mag & 64'h7FFFFF)) >> 23);
    return (z < 0) ? 65536 - v : v;
  endfunction

  function longint dot3(int w0, int w1, int w2, logic signed [15:0] xa,
                        logic signed [15:0] xb);
    return longint'(w0) * 256 + longint'(w1) * longint'(xa) + longint'(w2) * longint'(xb);
  endfunction

  // Batch gradient descent for one class, result into the next table slot
  function void fit(logic [7:0] target_cls);
    int     w [3];
    longint g [3];
    longint err;
    longint unsigned mag;
    longint unsigned p;
    longint nw;
    w = '{0, 0, 0};
    for (int unsigned it = 0; it < step_count; it++) begin
      g = '{0, 0, 0};
      for (int unsigned i = 0; i < sample_cnt; i++) begin
        err = squash(dot3(w[0], w[1], w[2], feat_a[i], feat_b[i]));
        if (labels[i] == target_cls) err -= 65536;
        g[0] += err * 256;
        g[1] += err * longint'(feat_a[i]);
        g[2] += err * longint'(feat_b[i]);
      end
      for (int j = 0; j < 3; j++) begin
        mag = (g[j] < 0) ? longint'(0) - g[j] : g[j];
        p = (longint'(step_rate) * (mag / sample_cnt)) >> 24;
        nw = (g[j] < 0) ? longint'(w[j]) + longint'(p) : longint'(w[j]) - longint'(p);
        if (nw > 64'sd2147483647) nw = 64'sd2147483647;
        if (nw < -64'sd2147483648) nw = -64'sd2147483648;
        w[j] = int'(nw);
      end
    end
    for (int j = 0; j < 3; j++) weights[model_cnt][j] = w[j];
    model_cls[model_cnt] = target_cls;
    model_cnt++;
  endfunction

  // Work out the result of one accepted transaction
  function void note_input(logic [1:0] op, logic signed [15:0] xa, logic signed [15:0] xb,
                           logic [7:0] lab);
    ovr_result_t r;
    int unsigned p;
    r = '{ovr_pkg::ST_OK, 8'd0, 16'd0};
    if (op == ovr_pkg::OP_LOAD) begin
      if (sample_cnt >= SAMPLE_DEPTH) r.status = ovr_pkg::ST_STORE_FULL;
      else begin
        feat_a[sample_cnt] = xa;
        feat_b[sample_cnt] = xb;
        labels[sample_cnt] = lab;
        sample_cnt++;
      end
    end else if (op == ovr_pkg::OP_TRAIN) begin
      if (sample_cnt == 0) r.status = ovr_pkg::ST_NO_SAMPLES;
      else if (model_cnt >= MODEL_DEPTH) r.status = ovr_pkg::ST_TABLE_FULL;
      else fit(lab);
    end else if (op == ovr_pkg::OP_PREDICT) begin
      for (int unsigned m = 0; m < model_cnt; m++) begin
        p = squash(dot3(weights[m][0], weights[m][1], weights[m][2], xa, xb));
        if (p > r.prob) begin
          r.prob = p[15:0];
          r.cls  = model_cls[m];
        end
      end
    end
    pending_q.insert(pending_q.size(), r);
  endfunction

  function void check(logic [1:0] st, logic [7:0] cls, logic [15:0] prob);
    ovr_result_t e;
    if (pending_q.size() == 0) begin
      $display("%0t: unexpected result status=%0d class=%0d prob=%0d", $time, st, cls, prob);
      errors++;
      return;
    end
    e = pending_q.pop_front();
    if (st !== e.status) begin
      $display("%0t: status expected %0d actual %0d", $time, e.status, st);
      errors++;
    end
    if (cls !== e.cls) begin
      $display("%0t: class expected %0d actual %0d", $time, e.cls, cls);
      errors++;
    end
    if (prob !== e.prob) begin
      $display("%0t: probability expected %0d actual %0d", $time, e.prob, prob);
      errors++;
    end
  endfunction
endclass

module tb_top;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [1:0]         opcode_i;
  logic signed [15:0] feature_a_i;
  logic signed [15:0] feature_b_i;
  logic [7:0]         class_label_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [1:0]         status_o;
  logic [7:0]         predicted_class_o;
  logic [15:0]        probability_o;
  logic               cfg_we_i;
  logic [ovr_pkg::CFG_IDX_W-1:0]  cfg_index_i;
  logic [ovr_pkg::CFG_DATA_W-1:0] cfg_data_i;

  ovr_scoreboard sb;
  int send_idle;
  int recv_idle;
  int hold_cycles;

  one_vs_rest_logistic_trainer_unit u_top (.*);

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Stall the result channel at random, or for a long hold when asked
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      out_stall_i = 1'b1;
      hold_cycles--;
    end else begin
      out_stall_i = ($urandom_range(99) < recv_idle);
    end
  end

  // Check every accepted result
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check(status_o, predicted_class_o, probability_o);
  end

  task automatic send(logic [1:0] op, logic [15:0] xa, logic [15:0] xb, logic [7:0] lab);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    = 1'b1;
    opcode_i      = op;
    feature_a_i   = xa;
    feature_b_i   = xb;
    class_label_i = lab;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(op, xa, xb, lab);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic write_reg(logic [ovr_pkg::CFG_IDX_W-1:0] idx,
                           logic [ovr_pkg::CFG_DATA_W-1:0] val);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic drain();
    while (sb.pending_q.size() > 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  function automatic logic [7:0] pick_label();
    return ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(3));
  endfunction

  // Mostly loads and predicts with a few trains; opcode 3 as noise
  task automatic run_random(int count);
    int sel;
    logic [1:0] op;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(99);
      if (sel < 44) op = ovr_pkg::OP_LOAD;
      else if (sel < 52) op = ovr_pkg::OP_TRAIN;
      else if (sel < 96) op = ovr_pkg::OP_PREDICT;
      else op = OP_UNUSED;
      send(op, 16'($urandom), 16'($urandom), pick_label());
    end
  endtask

  initial begin
    sb          = new();
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    out_stall_i = 1'b0;
    opcode_i    = ovr_pkg::OP_LOAD;
    feature_a_i = '0;
    feature_b_i = '0;
    class_label_i = '0;
    cfg_we_i    = 1'b0;
    cfg_index_i = ovr_pkg::CFG_LEARNING_RATE;
    cfg_data_i  = '0;
    send_idle   = 0;
    recv_idle   = 0;
    hold_cycles = 0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: empty table, empty store, extremes, zero-iteration model
    write_reg(ovr_pkg::CFG_ITERATION_COUNT, 20'hFFFFF);
    write_reg(ovr_pkg::CFG_LEARNING_RATE, 20'd65535);
    write_reg(ovr_pkg::CFG_ITERATION_COUNT, 20'd1);
    send(ovr_pkg::OP_PREDICT, 16'h0100, 16'h0100, 8'd0);
    send(ovr_pkg::OP_TRAIN, 16'h0000, 16'h0000, 8'd5);
    send(OP_UNUSED, 16'hFFFF, 16'hFFFF, 8'hFF);
    send(ovr_pkg::OP_LOAD, 16'h8000, 16'h7FFF, 8'd0);
    send(ovr_pkg::OP_LOAD, 16'h7FFF, 16'h8000, 8'hFF);
    send(ovr_pkg::OP_LOAD, 16'h0000, 16'h0000, 8'd0);
    send(ovr_pkg::OP_LOAD, 16'hFF00, 16'h0100, 8'd1);
    send(ovr_pkg::OP_TRAIN, 16'h0000, 16'h0000, 8'd0);
    send(ovr_pkg::OP_TRAIN, 16'hFFFF, 16'hFFFF, 8'hFF);
    send(ovr_pkg::OP_PREDICT, 16'h8000, 16'h8000, 8'd0);
    send(ovr_pkg::OP_PREDICT, 16'h7FFF, 16'h7FFF, 8'd0);
    send(ovr_pkg::OP_PREDICT, 16'h0000, 16'h0000, 8'd0);
    drain();
    write_reg(ovr_pkg::CFG_LEARNING_RATE, 20'd0);
    write_reg(ovr_pkg::CFG_ITERATION_COUNT, 20'd0);
    send(ovr_pkg::OP_TRAIN, 16'h0000, 16'h0000, 8'd1);
    send(ovr_pkg::OP_PREDICT, 16'h1234, 16'hEDCB, 8'd0);
    drain();

    // Random phase with the sender idling less than the receiver
    write_reg(ovr_pkg::CFG_LEARNING_RATE, 20'($urandom_range(65535)));
    write_reg(ovr_pkg::CFG_ITERATION_COUNT, 20'd2);
    send_idle = 33;
    recv_idle = 70;
    run_random(470);
    drain();

    // Random phase with the roles swapped; top up the model table
    write_reg(ovr_pkg::CFG_LEARNING_RATE, 20'($urandom_range(65535)));
    write_reg(ovr_pkg::CFG_ITERATION_COUNT, 20'd3);
    send_idle = 70;
    recv_idle = 33;
    run_random(470);
    while (sb.model_cnt < 8) send(ovr_pkg::OP_TRAIN, 16'h0000, 16'h0000, pick_label());
    drain();

    // Full speed with a long receiver hold so the input backs up
    write_reg(ovr_pkg::CFG_LEARNING_RATE, 20'd65535);
    write_reg(ovr_pkg::CFG_ITERATION_COUNT, 20'hFFFFF);
    send_idle   = 0;
    recv_idle   = 0;
    hold_cycles = 300;
    run_random(470);
    drain();

    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("simulation failed");
    $finish;
  end
endmodule

`default_nettype wire

@@ sim.f @@
src/ovr_pkg.sv
src/ovr_dpath.sv
src/ovr_ctrl.sv
src/one_vs_rest_logistic_trainer_unit.sv
dv/tb_top.sv
